FILE: sv/rar_pkg.sv
package rar_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int RES_NUM_W = 33;
  localparam int RES_DEN_W = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_SUM,
    ST_GCD,
    ST_QUOT,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic prod;
    logic sum;
    logic div_start;
    logic gcd_step;
    logic quot_start;
    logic quot_done;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic num_zero;
    logic y_zero;
    logic div_busy;
  } sts_t;

endpackage

FILE: sv/rar_if.sv
interface rar_in_if #(parameter int W = rar_pkg::OPERAND_WIDTH_DEF) (input logic clk);
  logic valid;
  logic ready;
  logic [1:0] opcode;
  logic signed [W-1:0] a_num;
  logic signed [W-1:0] a_den;
  logic signed [W-1:0] b_num;
  logic signed [W-1:0] b_den;
  modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rar_out_if (input logic clk);
  logic valid;
  logic ready;
  logic signed [rar_pkg::RES_NUM_W-1:0] res_num;
  logic signed [rar_pkg::RES_DEN_W-1:0] res_den;
  modport source (output valid, res_num, res_den, input ready);
  modport sink (input valid, res_num, res_den, output ready);
endinterface

FILE: sv/rational_arith_reduce.sv
// Exact rational add, subtract, multiply and divide with gcd reduction.
// in: valid/ready with opcode and four signed operands; a transfer starts
// one item. out: valid/ready with the reduced numerator and denominator.
// One item is in flight at a time; in_ready is high only while idle, so the
// next item can transfer in the cycle after the result transfer.
// Steps: load, products and sum, then a seed step; each Euclid step is
// one run of the shared bit-serial divider plus taking the remainder,
// then the zero remainder is seen and two quotient runs follow on the
// same divider.
// A zero numerator skips Euclid and gives 0/1.
// The result is held on out until the transfer completes; a stalled
// receiver holds the block and no new item is taken.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// any item in progress; no result is shown after reset until a new item.
module rational_arith_reduce #(
  parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
  input logic clk,
  input logic rst_n,
  rar_in_if.sink in_ch,
  rar_out_if.source out_ch
);
  rar_pkg::cmd_t cmd;
  rar_pkg::sts_t sts;
  logic zero_res;
  logic [rar_pkg::RES_NUM_W-1:0] rn;
  logic [rar_pkg::RES_DEN_W-1:0] rd;

  rar_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .cmd(cmd), .sts(sts),
    .zero_res(zero_res)
  );

  rar_datapath #(.W(OPERAND_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .opcode(in_ch.opcode),
    .a_num(in_ch.a_num), .a_den(in_ch.a_den), .b_num(in_ch.b_num),
    .b_den(in_ch.b_den), .res_num(rn), .res_den(rd)
  );

  // zero numerator gives 0/1
  assign out_ch.res_num = zero_res ? '0 : rn;
  assign out_ch.res_den = zero_res ? rar_pkg::RES_DEN_W'(1) : rd;
endmodule

FILE: sv/rar_div.sv
// Restoring unsigned divider, one quotient bit per cycle
module rar_div #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic [W:0] trial;

  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    d_nxt = d_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    trial = {r_r, q_r[W-1]};
    if (start) begin
      q_nxt = dividend;
      r_nxt = '0;
      d_nxt = divisor;
      cnt_nxt = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in one dividend bit and try a subtract
      if (trial >= {1'b0, d_r}) begin
        r_nxt = W'(trial - {1'b0, d_r});
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        r_nxt = trial[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) busy_r <= 1'b0;
    else busy_r <= busy_nxt;
  end

  assign busy = busy_r;
  assign quot = q_r;
  assign rem = r_r;
endmodule

FILE: sv/rar_datapath.sv
// Cross products, Euclid registers and the final quotients
module rar_datapath #(
  parameter int W = rar_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rar_pkg::cmd_t        cmd,
  output rar_pkg::sts_t        sts,
  input  logic [1:0]           opcode,
  input  logic [W-1:0]         a_num,
  input  logic [W-1:0]         a_den,
  input  logic [W-1:0]         b_num,
  input  logic [W-1:0]         b_den,
  output logic [rar_pkg::RES_NUM_W-1:0] res_num,
  output logic [rar_pkg::RES_DEN_W-1:0] res_den
);
  localparam int PW = 2 * W + 1;
  logic [W-1:0] an_r, ad_r, bn_r, bd_r;
  logic [W:0] anm, adm, bnm, bdm;
  logic [1:0] op_r;
  logic [PW-1:0] p_r, q_r, dm_r, nm_r, x_r, y_r;
  logic pn_r, qn_r, dn_r, nn_r, odd_r;
  logic [W:0] m1a, m1b, m2a, m2b;
  logic s1a, s1b, s2a, s2b;
  logic [PW-1:0] m1, m2;
  logic [PW-1:0] dv_a, dv_b, dq, dr;
  logic dbusy;
  logic [PW-1:0] rn_mag_r;
  logic [rar_pkg::RES_NUM_W-1:0] rn_out_r;
  logic [rar_pkg::RES_DEN_W-1:0] rd_out_r;
  logic gneg;

  function automatic logic [W:0] mag(input logic [W-1:0] v);
    mag = v[W-1] ? (W+1)'(-{1'b1, v}) : {1'b0, v};
  endfunction

  assign anm = mag(an_r);
  assign adm = mag(ad_r);
  assign bnm = mag(bn_r);
  assign bdm = mag(bd_r);

  // operand selection for the two products
  always_comb begin
    m1a = anm; s1a = an_r[W-1];
    m1b = bdm; s1b = bd_r[W-1];
    m2a = adm; s2a = ad_r[W-1];
    m2b = bdm; s2b = bd_r[W-1];
    if (op_r == rar_pkg::OP_MUL) begin
      m1b = bnm; s1b = bn_r[W-1];
    end else if (op_r == rar_pkg::OP_DIV) begin
      m2b = bnm; s2b = bn_r[W-1];
    end
  end
  assign m1 = PW'(m1a) * PW'(m1b);
  assign m2 = PW'(m2a) * PW'(m2b);

  assign gneg = odd_r ? dn_r : nn_r;
  // next Euclid division: numerator by denominator at the seed, then
  // old divisor by the remainder just taken
  assign dv_a = (rn_mag_r == '0) ? nm_r : y_r;
  assign dv_b = (rn_mag_r == '0) ? y_r : dr;

  rar_div #(.W(PW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start | cmd.quot_start),
    .dividend(cmd.quot_start ? (cmd.gcd_step ? dm_r : nm_r) : dv_a),
    .divisor(cmd.quot_start ? x_r : dv_b),
    .busy(dbusy), .quot(dq), .rem(dr)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      an_r <= a_num; ad_r <= a_den; bn_r <= b_num; bd_r <= b_den; op_r <= opcode;
    end
    if (cmd.prod) begin
      p_r <= m1;
      pn_r <= (m1 != '0) && (s1a != s1b);
      dm_r <= m2;
      dn_r <= (m2 != '0) && (s2a != s2b);
      q_r <= PW'(bnm) * PW'(adm);
      qn_r <= (bnm != '0) && (adm != '0) &&
              ((bn_r[W-1] != ad_r[W-1]) ^ (op_r == rar_pkg::OP_SUB));
    end
    if (cmd.sum) begin
      // signed magnitude sum, or the single product
      if (op_r == rar_pkg::OP_MUL || op_r == rar_pkg::OP_DIV) begin
        nm_r <= p_r; nn_r <= pn_r;
      end else if (pn_r == qn_r) begin
        nm_r <= p_r + q_r; nn_r <= pn_r;
      end else if (p_r >= q_r) begin
        nm_r <= p_r - q_r; nn_r <= (p_r != q_r) && pn_r;
      end else begin
        nm_r <= q_r - p_r; nn_r <= qn_r;
      end
      x_r <= '0;
      y_r <= dm_r;
      odd_r <= 1'b0;
      rn_mag_r <= '0;
    end
    if (cmd.gcd_step && !cmd.quot_start && !cmd.quot_done) begin
      // seed x with the numerator, or one Euclid step once remainder is ready
      if (rn_mag_r == '0) begin
        x_r <= nm_r; rn_mag_r <= {{(PW-1){1'b0}}, 1'b1};
      end else begin
        x_r <= y_r; y_r <= dr; odd_r <= ~odd_r;
      end
    end
    if (cmd.quot_done) begin
      if (cmd.gcd_step) begin
        rd_out_r <= ((dq != '0) && (dn_r != gneg)) ? -(rar_pkg::RES_DEN_W'(dq))
                                                   : rar_pkg::RES_DEN_W'(dq);
      end else begin
        rn_out_r <= ((dq != '0) && (nn_r != gneg)) ? -(rar_pkg::RES_NUM_W'(dq))
                                                   : rar_pkg::RES_NUM_W'(dq);
      end
    end
    if (cmd.load) begin
      rn_out_r <= rn_out_r;
    end
  end

  assign sts.num_zero = (nm_r == '0);
  assign sts.y_zero = (y_r == '0);
  assign sts.div_busy = dbusy;
  assign res_num = rn_out_r;
  assign res_den = rd_out_r;
endmodule

FILE: sv/rar_ctrl.sv
// Sequencer: products, sum, Euclid loop, two quotients, output hold
module rar_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output rar_pkg::cmd_t cmd,
  input  rar_pkg::sts_t sts,
  output logic          zero_res
);
  rar_pkg::state_t st_r, st_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic started_r, started_nxt;
  logic zero_r, zero_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rar_pkg::ST_IDLE;
      ph_r <= '0;
      started_r <= 1'b0;
      zero_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ph_r <= ph_nxt;
      started_r <= started_nxt;
      zero_r <= zero_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    ph_nxt = ph_r;
    started_nxt = started_r;
    zero_nxt = zero_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (st_r)
      rar_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          st_nxt = rar_pkg::ST_PROD;
        end
      end
      rar_pkg::ST_PROD: begin
        cmd.prod = 1'b1;
        st_nxt = rar_pkg::ST_SUM;
      end
      rar_pkg::ST_SUM: begin
        cmd.sum = 1'b1;
        started_nxt = 1'b0;
        st_nxt = rar_pkg::ST_GCD;
      end
      rar_pkg::ST_GCD: begin
        if (sts.num_zero) begin
          zero_nxt = 1'b1;
          st_nxt = rar_pkg::ST_OUT;
        end else if (!started_r) begin
          // seed x with the numerator, first step
          cmd.gcd_step = 1'b1;
          started_nxt = 1'b1;
          zero_nxt = 1'b0;
          if (!sts.y_zero) cmd.div_start = 1'b1;
        end else if (sts.y_zero) begin
          ph_nxt = 2'd0;
          st_nxt = rar_pkg::ST_QUOT;
        end else if (!sts.div_busy) begin
          // take the remainder and start the next division
          cmd.gcd_step = 1'b1;
          cmd.div_start = 1'b1;
        end
      end
      rar_pkg::ST_QUOT: begin
        // ph 0: start num, 1: wait/take num, 2: start den, 3: wait/take den
        unique case (ph_r)
          2'd0: begin
            cmd.quot_start = 1'b1;
            ph_nxt = 2'd1;
          end
          2'd1: begin
            if (!sts.div_busy) begin
              cmd.quot_done = 1'b1;
              ph_nxt = 2'd2;
            end
          end
          2'd2: begin
            cmd.quot_start = 1'b1;
            cmd.gcd_step = 1'b1;
            ph_nxt = 2'd3;
          end
          default: begin
            if (!sts.div_busy) begin
              cmd.quot_done = 1'b1;
              cmd.gcd_step = 1'b1;
              st_nxt = rar_pkg::ST_OUT;
            end
          end
        endcase
      end
      rar_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) st_nxt = rar_pkg::ST_IDLE;
      end
      default: st_nxt = rar_pkg::ST_IDLE;
    endcase
  end

  assign zero_res = zero_r;
endmodule

FILE: sv/rar_checker.sv
module rar_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [rar_pkg::RES_NUM_W-1:0] res_num,
  input logic [rar_pkg::RES_DEN_W-1:0] res_den
);
  // one item at a time: never ready while a result waits
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  // a taken input is not followed by ready next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after transfer");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(res_num) && $stable(res_den)))
    else $error("stalled result changed");
  // zero numerator always reduces to denominator one
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && res_num == '0) |-> (res_den == rar_pkg::RES_DEN_W'(1)))
    else $error("zero numerator not over one");
endmodule

bind rational_arith_reduce rar_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .res_num(out_ch.res_num), .res_den(out_ch.res_den)
);

FILE: dv/rational_arith_reduce_tb.sv
module rational_arith_reduce_tb;

  localparam int W = rar_pkg::OPERAND_WIDTH_DEF;
  localparam int IDLE_LIMIT = 20000;
  localparam int N_RANDOM = 1200;

  typedef struct {
    rar_pkg::opcode_t op;
    logic signed [W-1:0] an, ad, bn, bd;
  } frac_pair_t;

  typedef struct {
    logic signed [rar_pkg::RES_NUM_W-1:0] num;
    logic signed [rar_pkg::RES_DEN_W-1:0] den;
  } reduced_t;

  // directed row: operands plus optional typed-in answer
  typedef struct {
    frac_pair_t item;
    bit known;
    reduced_t ans;
  } row_t;

  logic clk;
  logic rst_n;

  rar_in_if #(.W(W)) in_ch (clk);
  rar_out_if out_ch (clk);

  rational_arith_reduce #(.OPERAND_WIDTH(W)) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  reduced_t pending_results[$];
  int errors;
  int idle_cycles;
  bit stim_done;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // exact reduction of a fraction, truncating Euclid with signed gcd
  function automatic reduced_t reduce_frac(frac_pair_t it);
    longint an, ad, bn, bd, num, den, x, y, t, g;
    reduced_t r;
    an = it.an; ad = it.ad; bn = it.bn; bd = it.bd;
    case (it.op)
      rar_pkg::OP_ADD: begin num = an * bd + bn * ad; den = ad * bd; end
      rar_pkg::OP_SUB: begin num = an * bd - bn * ad; den = ad * bd; end
      rar_pkg::OP_MUL: begin num = an * bn; den = ad * bd; end
      default: begin num = an * bd; den = ad * bn; end
    endcase
    if (num == 0) begin
      r.num = '0;
      r.den = 1;
    end else begin
      x = num;
      y = den;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      g = x;
      r.num = rar_pkg::RES_NUM_W'(num / g);
      r.den = rar_pkg::RES_DEN_W'(den / g);
    end
    return r;
  endfunction

  // one transfer on the input channel
  task automatic send_item(frac_pair_t it);
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= it.op;
    in_ch.a_num  <= it.an;
    in_ch.a_den  <= it.ad;
    in_ch.b_num  <= it.bn;
    in_ch.b_den  <= it.bd;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic idle_gap(int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [W-1:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(W-1){1'b0}}};
      1: return {1'b0, {(W-1){1'b1}}};
      2: return '0;
      3: return W'($urandom_range(0, 2)) - W'(1);
      4: return W'($urandom_range(0, 30)) - W'(15);
      5: return W'($urandom_range(0, 16)) * W'(12);
      default: return W'($urandom);
    endcase
  endfunction

  function automatic frac_pair_t rand_item();
    frac_pair_t it;
    it.op = rar_pkg::opcode_t'($urandom_range(0, 3));
    it.an = rand_operand();
    it.ad = rand_operand();
    it.bn = rand_operand();
    it.bd = rand_operand();
    // mostly keep denominators nonzero, still reach the zero cases
    if ($urandom_range(0, 15) != 0) begin
      if (it.ad == 0) it.ad = 1;
      if (it.bd == 0) it.bd = -1;
    end
    return it;
  endfunction

  function automatic row_t mk_row(rar_pkg::opcode_t op, int an, int ad, int bn, int bd,
                                  bit known = 0, longint rn = 0, longint rd = 0);
    row_t r;
    r.item.op = op;
    r.item.an = W'(an);
    r.item.ad = W'(ad);
    r.item.bn = W'(bn);
    r.item.bd = W'(bd);
    r.known = known;
    r.ans.num = rar_pkg::RES_NUM_W'(rn);
    r.ans.den = rar_pkg::RES_DEN_W'(rd);
    return r;
  endfunction

  // stimulus
  initial begin
    row_t directed[$];
    frac_pair_t it;
    int burst;
    in_ch.valid  <= 1'b0;
    in_ch.opcode <= rar_pkg::OP_ADD;
    in_ch.a_num  <= '0;
    in_ch.a_den  <= '0;
    in_ch.b_num  <= '0;
    in_ch.b_den  <= '0;
    stim_done = 1'b0;
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(mk_row(rar_pkg::OP_ADD, 1, 2, 1, 2, 1, 1, 1));
    directed.push_back(mk_row(rar_pkg::OP_SUB, 1, 2, 1, 2, 1, 0, 1));
    directed.push_back(mk_row(rar_pkg::OP_MUL, 0, 0, 5, 7, 1, 0, 1));
    directed.push_back(mk_row(rar_pkg::OP_DIV, 3, 4, 0, 5, 1, 1, 0));
    directed.push_back(mk_row(rar_pkg::OP_DIV, -3, 4, 0, 5, 1, 1, 0));
    directed.push_back(mk_row(rar_pkg::OP_MUL, 2, 3, 3, 2, 1, 1, 1));
    directed.push_back(mk_row(rar_pkg::OP_MUL, -32768, 1, -32768, 1, 1, 1073741824, 1));
    directed.push_back(mk_row(rar_pkg::OP_ADD, -32768, 1, -32768, 1, 1, -65536, 1));
    directed.push_back(mk_row(rar_pkg::OP_SUB, 32767, 1, -32768, 1, 1, 65535, 1));
    directed.push_back(mk_row(rar_pkg::OP_MUL, 1, -32768, 1, -32768, 1, 1, 1073741824));
    directed.push_back(mk_row(rar_pkg::OP_ADD, 32767, 32767, 32767, 32767));
    directed.push_back(mk_row(rar_pkg::OP_DIV, 32767, -32768, -32768, 32767));
    directed.push_back(mk_row(rar_pkg::OP_ADD, 1, 0, 1, 0));
    directed.push_back(mk_row(rar_pkg::OP_SUB, -5, 3, 7, -6));
    directed.push_back(mk_row(rar_pkg::OP_MUL, -6, 4, 10, -9));
    directed.push_back(mk_row(rar_pkg::OP_DIV, -1, -1, -1, -1));
    directed.push_back(mk_row(rar_pkg::OP_MUL, 4, -6, 3, 1));
    directed.push_back(mk_row(rar_pkg::OP_ADD, 0, 5, 0, -5));
    directed.push_back(mk_row(rar_pkg::OP_DIV, 0, 0, 0, 0));

    foreach (directed[i]) begin
      pending_results.push_back(directed[i].known ? directed[i].ans
                                                  : reduce_frac(directed[i].item));
      send_item(directed[i].item);
      if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 5));
    end

    // hold off until every result has drained
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    // random bursts with random gaps
    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
        it = rand_item();
        pending_results.push_back(reduce_frac(it));
        send_item(it);
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 80));
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver stall pattern: alternating free-running and stalled phases
  initial begin
    int phase;
    out_ch.ready <= 1'b0;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if (phase < 400) out_ch.ready <= 1'b1;
      else if (phase < 1200) out_ch.ready <= ($urandom_range(0, 3) != 0);
      else if (phase < 1400) out_ch.ready <= ($urandom_range(0, 7) == 0);
      else phase = 0;
    end
  end

  // result check and watchdog
  initial begin
    reduced_t exp_r;
    errors = 0;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst_n && in_ch.valid && in_ch.ready) idle_cycles = 0;
      if (rst_n && out_ch.valid && out_ch.ready) begin
        idle_cycles = 0;
        if (pending_results.size() == 0) begin
          $error("unexpected result num=%0d den=%0d", out_ch.res_num, out_ch.res_den);
          errors++;
        end else begin
          exp_r = pending_results.pop_front();
          if (out_ch.res_num !== exp_r.num) begin
            $error("res_num expected %0d got %0d", exp_r.num, out_ch.res_num);
            errors++;
          end
          if (out_ch.res_den !== exp_r.den) begin
            $error("res_den expected %0d got %0d", exp_r.den, out_ch.res_den);
            errors++;
          end
        end
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // end of run
  initial begin
    @(posedge clk);
    while (!(stim_done && pending_results.size() == 0)) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
